>>> rtl/abd_pkg.sv
`default_nettype none
package abd_pkg;

   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned INDEX_W   = 32;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned NEED_W    = SAMPLE_W + PCT_W;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [SAMPLE_W-1:0] JUMP_THR_RESET   = 16'd1200;
   localparam logic [SAMPLE_W-1:0] LEVEL_THR_RESET  = 16'd1005;
   localparam logic [SAMPLE_W-1:0] WINDOW_LEN_RESET = 16'd1600;
   localparam logic [PCT_W-1:0]    UPLOAD_PCT_RESET = 7'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JUMP_THR   = 2'd0,
      CSR_LEVEL_THR  = 2'd1,
      CSR_WINDOW_LEN = 2'd2,
      CSR_UPLOAD_PCT = 2'd3
   } csr_index_type;

   // thresholds as seen by the datapath; need is upload_percent * window_length
   typedef struct packed {
      logic [SAMPLE_W-1:0] jump_thr;
      logic [SAMPLE_W-1:0] level_thr;
      logic [NEED_W-1:0]   need;
   } cfg_type;

   typedef struct packed {
      logic               marked;
      logic               upload;
      logic [INDEX_W-1:0] span_first;
      logic [INDEX_W-1:0] span_last;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/abd_req_if.sv
`default_nettype none
interface abd_req_if import abd_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] accel_sample;

   modport source (output valid, output accel_sample, input ready);
   modport sink (input valid, input accel_sample, output ready);
endinterface
`default_nettype wire

>>> rtl/abd_rsp_if.sv
`default_nettype none
interface abd_rsp_if import abd_pkg::*;;
   logic               valid;
   logic               ready;
   logic               marked;
   logic               upload;
   logic [INDEX_W-1:0] span_first;
   logic [INDEX_W-1:0] span_last;

   modport source (output valid, output marked, output upload, output span_first,
                   output span_last, input ready);
   modport sink (input valid, input marked, input upload, input span_first,
                 input span_last, output ready);
endinterface
`default_nettype wire

>>> rtl/activity_burst_detector_unit.sv
// Activity burst detector.
// req_chan carries one 16-bit acceleration magnitude per item; rsp_chan returns
// exactly one result per item: marked, upload and the first and last marked
// sample indices (zero unless upload is set). Both are valid/ready channels;
// an item moves on a rising edge with valid and ready high.
// The csr_ port writes the four thresholds by index on any edge with csr_we
// high; write only while no item is in flight.
// An accepted item sits in the input register until the mark/upload logic
// loads the result register, which raises rsp_chan.valid; the result leaves
// when rsp_chan.ready is high. One item per cycle is sustained while the
// receiver does not stall; the mark count and indices carried from one sample
// to the next are updated in a single step, which allows that rate.
// When the receiver stalls, the result register holds and one more item is
// taken into the input register; req_chan.ready then drops until the result
// is taken.
// Synchronous reset clears the thresholds to their defaults, the previous
// sample, the sample index and the mark count, and empties both stages.
`default_nettype none
module activity_burst_detector_unit import abd_pkg::*; #(
   parameter int unsigned MAX_MARKS = 54
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   abd_req_if.sink                    req_chan,
   abd_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   result_type result;

   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic step;
   logic accept;

   abd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   abd_core #(.MAX_MARKS(MAX_MARKS)) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .load   (accept),
      .sample (req_chan.accel_sample),
      .step   (step),
      .result (result)
   );

   always_comb begin
      advance = !out_valid_ff || rsp_chan.ready;
      step    = s1_valid_ff && advance;
      req_chan.ready = !s1_valid_ff || advance;
      accept  = req_chan.valid && req_chan.ready;

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.marked     = result.marked;
   assign rsp_chan.upload     = result.upload;
   assign rsp_chan.span_first = result.span_first;
   assign rsp_chan.span_last  = result.span_last;

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while both stages are full");

   a_step_fills_out: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("item advanced but no result shown");

   a_idle_empties: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && !accept && out_valid_ff && rsp_chan.ready) |=> !out_valid_ff)
      else $error("result repeated after it was taken");

endmodule
`default_nettype wire

>>> rtl/abd_csr.sv
`default_nettype none
module abd_csr import abd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   logic [SAMPLE_W-1:0] jump_ff, jump_in;
   logic [SAMPLE_W-1:0] level_ff, level_in;
   logic [SAMPLE_W-1:0] window_ff, window_in;
   logic [PCT_W-1:0]    pct_ff, pct_in;
   logic [NEED_W-1:0]   need_ff, need_in;

   always_comb begin
      jump_in   = jump_ff;
      level_in  = level_ff;
      window_in = window_ff;
      pct_in    = pct_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_JUMP_THR:   jump_in   = csr_wdata;
            CSR_LEVEL_THR:  level_in  = csr_wdata;
            CSR_WINDOW_LEN: window_in = csr_wdata;
            CSR_UPLOAD_PCT: pct_in    = csr_wdata[PCT_W-1:0];
         endcase
      end
      // product is registered from the stored percent and window registers, behind the registers a write loads
      need_in = NEED_W'(pct_ff) * NEED_W'(window_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_ff   <= JUMP_THR_RESET;
         level_ff  <= LEVEL_THR_RESET;
         window_ff <= WINDOW_LEN_RESET;
         pct_ff    <= UPLOAD_PCT_RESET;
         need_ff   <= NEED_W'(UPLOAD_PCT_RESET) * NEED_W'(WINDOW_LEN_RESET);
      end else begin
         jump_ff   <= jump_in;
         level_ff  <= level_in;
         window_ff <= window_in;
         pct_ff    <= pct_in;
         need_ff   <= need_in;
      end
   end

   assign cfg.jump_thr  = jump_ff;
   assign cfg.level_thr = level_ff;
   assign cfg.need      = need_ff;

endmodule
`default_nettype wire

>>> rtl/abd_core.sv
`default_nettype none
module abd_core import abd_pkg::*; #(
   parameter int unsigned MAX_MARKS = 54
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                load,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                step,
   output result_type               result
);

   localparam int unsigned CNT_W = $clog2(MAX_MARKS + 1);
   localparam int unsigned REL_W = INDEX_W + 1;
   localparam int unsigned PROD_W = REL_W + 7;

   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] prev_ff;
   logic [INDEX_W-1:0]  ctr_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [INDEX_W-1:0]  first_ff, first_in;
   logic [INDEX_W-1:0]  last_ff, last_in;
   result_type          result_ff, result_in;

   logic [SAMPLE_W-1:0] jump;
   logic                mark;
   logic [CNT_W-1:0]    cnt_mark;
   logic [INDEX_W-1:0]  span;
   logic [REL_W-1:0]    relevant;
   logic [PROD_W-1:0]   rel_x100;
   logic                upload;

   always_comb begin
      jump = (sample_ff > prev_ff) ? (sample_ff - prev_ff) : (prev_ff - sample_ff);
      mark = (jump >= cfg.jump_thr) &&
             ((prev_ff >= cfg.level_thr) || (sample_ff >= cfg.level_thr));

      first_in = (mark && (cnt_ff == '0)) ? ctr_ff : first_ff;
      last_in  = mark ? ctr_ff : last_ff;
      cnt_mark = mark ? cnt_ff + CNT_W'(1) : cnt_ff;

      span     = last_in - first_in;
      relevant = {1'b0, span} + REL_W'(cnt_mark) - REL_W'(1);
      // times 100 as 64 + 32 + 4
      rel_x100 = PROD_W'({relevant, 6'b0}) + PROD_W'({relevant, 5'b0}) +
                 PROD_W'({relevant, 2'b0});
      upload   = (cnt_mark >= CNT_W'(2)) && (rel_x100 >= PROD_W'(cfg.need));

      cnt_in = cnt_mark;
      if (upload || (cnt_mark >= CNT_W'(MAX_MARKS))) begin
         cnt_in = '0;
      end

      result_in.marked     = mark;
      result_in.upload     = upload;
      result_in.span_first = upload ? first_in : '0;
      result_in.span_last  = upload ? last_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         ctr_ff  <= '0;
         cnt_ff  <= '0;
      end else if (step) begin
         prev_ff <= sample_ff;
         ctr_ff  <= ctr_ff + INDEX_W'(1);
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample;
      end
      if (step) begin
         first_ff  <= first_in;
         last_ff   <= last_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   a_cnt_below_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(MAX_MARKS))
      else $error("mark count reached its limit without clearing");

   a_upload_clears: assert property (@(posedge clock) disable iff (reset)
      (step && upload) |=> (cnt_ff == '0))
      else $error("marks not cleared after upload");

   a_ctr_advance: assert property (@(posedge clock) disable iff (reset)
      step |=> (ctr_ff == $past(ctr_ff) + INDEX_W'(1)))
      else $error("sample index did not advance by one");

endmodule
`default_nettype wire

>>> sim/activity_burst_detector_unit_test.sv
`default_nettype none
module activity_burst_detector_unit_test import abd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_MARKS = 54;
   localparam int unsigned IDLE_LIMIT = 5000;
   localparam int unsigned SHOW_LIMIT = 10;

   localparam logic [SAMPLE_W-1:0] DEFAULT_RUN [12] = '{
      16'd0, 16'd1200, 16'd0, 16'd1199, 16'd2399, 16'd1199,
      16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd1004, 16'd2204
   };
   localparam logic [SAMPLE_W-1:0] ZERO_WINDOW_RUN [6] = '{
      16'd0, 16'd65535, 16'd0, 16'd65535, 16'd32768, 16'd1
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   abd_req_if req_if ();
   abd_rsp_if rsp_if ();

   activity_burst_detector_unit #(.MAX_MARKS(MAX_MARKS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // detector copy: thresholds and carried state
   logic [SAMPLE_W-1:0] cfg_jump;
   logic [SAMPLE_W-1:0] cfg_level;
   logic [SAMPLE_W-1:0] cfg_window;
   logic [PCT_W-1:0]    cfg_pct;
   logic [SAMPLE_W-1:0] last_sample;
   logic [INDEX_W-1:0]  sample_idx;
   logic [5:0]          mark_cnt;
   logic [INDEX_W-1:0]  first_idx;
   logic [INDEX_W-1:0]  last_idx;

   logic [SAMPLE_W-1:0] sample_q[$];
   result_type          burst_q[$];
   logic [SAMPLE_W-1:0] gen_prev;
   int unsigned         items_queued;
   int unsigned         results_seen;
   int unsigned         send_idle_pct;
   int unsigned         recv_idle_pct;
   int unsigned         fail_count;
   int unsigned         shown_count;
   int unsigned         quiet_cycles;

   function automatic result_type detect_burst(logic [SAMPLE_W-1:0] cur);
      logic [SAMPLE_W-1:0] jump;
      logic [63:0]         relevant;
      logic [63:0]         need;
      result_type          res;
      res = '0;
      jump = (cur > last_sample) ? cur - last_sample : last_sample - cur;
      if (jump >= cfg_jump && (last_sample >= cfg_level || cur >= cfg_level)) begin
         res.marked = 1'b1;
         if (mark_cnt == 6'd0) first_idx = sample_idx;
         last_idx = sample_idx;
         mark_cnt = mark_cnt + 6'd1;
      end
      if (mark_cnt >= 6'd2) begin
         relevant = 64'(INDEX_W'(last_idx - first_idx)) + 64'(mark_cnt) - 64'd1;
         need = 64'(cfg_pct) * 64'(cfg_window);
         if (relevant * 64'd100 >= need) begin
            res.upload = 1'b1;
            res.span_first = first_idx;
            res.span_last = last_idx;
            mark_cnt = 6'd0;
         end else if (mark_cnt >= 6'(MAX_MARKS)) begin
            mark_cnt = 6'd0;
         end
      end
      last_sample = cur;
      sample_idx = sample_idx + INDEX_W'(1);
      return res;
   endfunction

   // bias samples toward the mark boundaries of the current thresholds
   function automatic logic [SAMPLE_W-1:0] next_sample(logic [SAMPLE_W-1:0] prev);
      int p;
      int d;
      int v;
      p = prev;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom_range(0, 65535);
         2, 3, 4: begin
            d = cfg_jump + $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0 && cfg_jump > 0) d = cfg_jump - 1;
            v = $urandom_range(0, 1) ? p + d : p - d;
            if (v > 65535) v = p - d;
            if (v < 0) v = p + d;
            if (v > 65535 || v < 0) v = $urandom_range(0, 65535);
         end
         5, 6: begin
            v = p + $urandom_range(0, 30) - 15;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
         end
         7: v = $urandom_range(0, 1) ? 65535 : 0;
         8: begin
            v = cfg_level;
            if ($urandom_range(0, 1) && v > 0) v = v - 1;
         end
         default: v = p;
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic queue_sample(logic [SAMPLE_W-1:0] value);
      sample_q.push_back(value);
      gen_prev = value;
      items_queued++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_JUMP_THR:   cfg_jump = value;
         CSR_LEVEL_THR:  cfg_level = value;
         CSR_WINDOW_LEN: cfg_window = value;
         CSR_UPLOAD_PCT: cfg_pct = value[PCT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (results_seen < items_queued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic run_random(logic [15:0] jump, logic [15:0] level, logic [15:0] window,
                             logic [15:0] pct, int unsigned count,
                             int unsigned send_pct, int unsigned recv_pct);
      wait_drained();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      write_reg(CSR_JUMP_THR, jump);
      write_reg(CSR_LEVEL_THR, level);
      write_reg(CSR_WINDOW_LEN, window);
      write_reg(CSR_UPLOAD_PCT, pct);
      end_writes();
      repeat (count) queue_sample(next_sample(gen_prev));
   endtask

   // sender: predict on each accepted item, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) burst_q.push_back(detect_burst(req_if.accel_sample));
         if (!req_if.valid || req_if.ready) begin
            if (sample_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_if.valid <= 1'b1;
               req_if.accel_sample <= sample_q.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each result against the oldest prediction
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            got.marked = rsp_if.marked;
            got.upload = rsp_if.upload;
            got.span_first = rsp_if.span_first;
            got.span_last = rsp_if.span_last;
            if (burst_q.size() == 0) begin
               fail_count++;
               if (shown_count < SHOW_LIMIT) begin
                  shown_count++;
                  $display("unexpected result: marked=%0d upload=%0d first=%0d last=%0d",
                           got.marked, got.upload, got.span_first, got.span_last);
               end
            end else begin
               want = burst_q.pop_front();
               if (got.marked !== want.marked || got.upload !== want.upload ||
                   got.span_first !== want.span_first || got.span_last !== want.span_last) begin
                  fail_count++;
                  if (shown_count < SHOW_LIMIT) begin
                     shown_count++;
                     $display("mismatch: expected marked=%0d upload=%0d first=%0d last=%0d",
                              want.marked, want.upload, want.span_first, want.span_last);
                     $display("          actual   marked=%0d upload=%0d first=%0d last=%0d",
                              got.marked, got.upload, got.span_first, got.span_last);
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_JUMP_THR;
      csr_wdata <= '0;
      cfg_jump = JUMP_THR_RESET;
      cfg_level = LEVEL_THR_RESET;
      cfg_window = WINDOW_LEN_RESET;
      cfg_pct = UPLOAD_PCT_RESET;
      last_sample = '0;
      sample_idx = '0;
      mark_cnt = '0;
      first_idx = '0;
      last_idx = '0;
      gen_prev = '0;
      items_queued = 0;
      results_seen = 0;
      fail_count = 0;
      shown_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 34;
      recv_idle_pct = 52;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // thresholds at their reset values, boundaries of jump and level
      foreach (DEFAULT_RUN[i]) queue_sample(DEFAULT_RUN[i]);

      // zero window: any pair of marks uploads
      wait_drained();
      write_reg(CSR_WINDOW_LEN, 16'd0);
      end_writes();
      foreach (ZERO_WINDOW_RUN[i]) queue_sample(ZERO_WINDOW_RUN[i]);

      // every sample marks; upload lands exactly on the full count
      run_random(16'd0, 16'd0, 16'd106, 16'd100, 60, 34, 52);
      // one step short of it: silent clear at the full count
      run_random(16'd0, 16'd0, 16'd107, 16'd100, 60, 34, 52);
      run_random(16'd65535, 16'd65535, 16'd1, 16'd0, 40, 34, 52);
      run_random(16'd500, 16'd2000, 16'd200, 16'd30, 60, 52, 34);
      run_random(16'd1200, 16'd1005, 16'd40, 16'd100, 60, 52, 34);
      // percent above 100 with the widest window
      run_random(16'd0, 16'd65535, 16'd65535, 16'd127, 40, 52, 34);
      repeat (3) begin
         run_random(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(1, 300)), 16'($urandom_range(0, 127)), 45, 0, 0);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && burst_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
